// File: design/bsl_pkg.sv
// ----------------------------------------------------------------------------
// bsl_pkg: shared types and constants for the bounded sequence list
// Field widths, list geometry, operation and status codes, cell commands.
// ----------------------------------------------------------------------------
package bsl_pkg;

    localparam int DEPTH     = 16;
    localparam int WORD_BITS = 32;

    localparam int MODE_W   = 3;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 5;
    localparam int STATUS_W = 2;
    localparam int FILL_W   = 5;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef logic [WORD_BITS-1:0] t_word;
    typedef logic [IDX_W-1:0]     t_idx;
    typedef logic [CNT_W-1:0]     t_cnt;

    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH_FRONT = 3'd0,
        MODE_PUSH_BACK  = 3'd1,
        MODE_INSERT     = 3'd2,
        MODE_POP_FRONT  = 3'd3,
        MODE_POP_BACK   = 3'd4,
        MODE_READ       = 3'd5
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_BADPOS = 2'd2,
        ST_FULL   = 2'd3
    } t_status;

    // What every cell of the row does this cycle, relative to index "at"
    typedef enum logic [1:0] {
        ACT_HOLD  = 2'd0,   // keep; "at" still selects the read tap
        ACT_OPEN  = 2'd1,   // cells above at take left neighbor, at loads word
        ACT_CLOSE = 2'd2,   // cells at and above take right neighbor
        ACT_LOAD  = 2'd3    // only cell at loads word
    } t_act;

    typedef struct packed {
        t_act  act;
        t_idx  at;
        t_word word;
    } t_cell_cmd;

    typedef struct packed {
        t_status status;
        logic    rd_ok;
        t_cnt    next_count;
    } t_ctrl_res;

    function automatic t_word to_word(input logic [VALUE_W-1:0] v);
        return WORD_BITS'($unsigned(v));
    endfunction

    function automatic logic [VALUE_W-1:0] from_word(input t_word w);
        return VALUE_W'(w);
    endfunction

endpackage

// File: design/bsl_in_if.sv
// ----------------------------------------------------------------------------
// bsl_in_if: operation channel of the bounded sequence list
// Valid/ready handshake carrying mode, item value and position.
// ----------------------------------------------------------------------------
interface bsl_in_if;
    logic                                valid;
    logic                                ready;
    logic        [bsl_pkg::MODE_W-1:0]   mode;
    logic signed [bsl_pkg::VALUE_W-1:0]  item_value;
    logic        [bsl_pkg::POS_W-1:0]    position;

    modport source (output valid, mode, item_value, position, input ready);
    modport sink   (input valid, mode, item_value, position, output ready);
endinterface

// File: design/bsl_out_if.sv
// ----------------------------------------------------------------------------
// bsl_out_if: result channel of the bounded sequence list
// Valid/ready handshake carrying status, read value and fill count.
// ----------------------------------------------------------------------------
interface bsl_out_if;
    logic                                valid;
    logic                                ready;
    logic        [bsl_pkg::STATUS_W-1:0] status;
    logic signed [bsl_pkg::VALUE_W-1:0]  read_value;
    logic        [bsl_pkg::FILL_W-1:0]   fill_count;

    modport source (output valid, status, read_value, fill_count, input ready);
    modport sink   (input valid, status, read_value, fill_count, output ready);
endinterface

// File: design/bsl_cell.sv
// ----------------------------------------------------------------------------
// bsl_cell: one storage cell of the list row
// Holds one word; per cycle holds, loads, or takes a neighbor's word.
// ----------------------------------------------------------------------------
module bsl_cell (
    input  logic               i_clk,
    input  bsl_pkg::t_idx      i_index,
    input  bsl_pkg::t_cell_cmd i_cmd,
    input  bsl_pkg::t_word     i_left,
    input  bsl_pkg::t_word     i_right,
    output bsl_pkg::t_word     o_word,
    output bsl_pkg::t_word     o_tap
);
    import bsl_pkg::*;

    t_word r_word;
    t_word n_word;

    always_comb begin
        n_word = r_word;
        case (i_cmd.act)
            ACT_OPEN: begin
                if (i_index > i_cmd.at) begin
                    n_word = i_left;
                end else if (i_index == i_cmd.at) begin
                    n_word = i_cmd.word;
                end
            end
            ACT_CLOSE: begin
                if (i_index >= i_cmd.at) begin
                    n_word = i_right;
                end
            end
            ACT_LOAD: begin
                if (i_index == i_cmd.at) begin
                    n_word = i_cmd.word;
                end
            end
            default: n_word = r_word;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word = r_word;
    assign o_tap  = (i_index == i_cmd.at) ? r_word : '0;

endmodule

// File: design/bsl_ctrl.sv
// ----------------------------------------------------------------------------
// bsl_ctrl: operation decoder for the bounded sequence list
// Checks an item against the count, picks the row command and status.
// ----------------------------------------------------------------------------
module bsl_ctrl (
    input  logic                         i_fire,
    input  logic [bsl_pkg::MODE_W-1:0]   i_mode,
    input  logic [bsl_pkg::VALUE_W-1:0]  i_value,
    input  logic [bsl_pkg::POS_W-1:0]    i_position,
    input  bsl_pkg::t_cnt                i_count,
    output bsl_pkg::t_cell_cmd           o_cmd,
    output bsl_pkg::t_ctrl_res           o_res
);
    import bsl_pkg::*;

    logic [CMP_W-1:0] pos_c;
    logic [CMP_W-1:0] cnt_c;
    logic [CMP_W-1:0] ins_k;
    logic             full;
    logic             empty;
    t_cell_cmd        cmd;

    assign pos_c = CMP_W'(i_position);
    assign cnt_c = CMP_W'(i_count);
    assign ins_k = (pos_c == '0) ? CMP_W'(1) : pos_c;
    assign full  = (i_count >= CNT_W'(DEPTH));
    assign empty = (i_count == '0);

    always_comb begin
        cmd              = '{act: ACT_HOLD, at: '0, word: to_word(i_value)};
        o_res.status     = ST_OK;
        o_res.rd_ok      = 1'b0;
        o_res.next_count = i_count;
        unique case (t_mode'(i_mode))
            MODE_PUSH_FRONT: begin
                if (full) begin
                    o_res.status = ST_FULL;
                end else begin
                    cmd.act          = ACT_OPEN;
                    o_res.next_count = CNT_W'(i_count + 1'b1);
                end
            end
            MODE_PUSH_BACK: begin
                if (full) begin
                    o_res.status = ST_FULL;
                end else begin
                    cmd.act          = ACT_LOAD;
                    cmd.at           = IDX_W'(i_count);
                    o_res.next_count = CNT_W'(i_count + 1'b1);
                end
            end
            MODE_INSERT: begin
                if (ins_k > cnt_c) begin
                    o_res.status = ST_BADPOS;
                end else if (full) begin
                    o_res.status = ST_FULL;
                end else begin
                    cmd.act          = ACT_OPEN;
                    cmd.at           = IDX_W'(ins_k);
                    o_res.next_count = CNT_W'(i_count + 1'b1);
                end
            end
            MODE_POP_FRONT: begin
                if (empty) begin
                    o_res.status = ST_EMPTY;
                end else begin
                    cmd.act          = ACT_CLOSE;
                    o_res.next_count = CNT_W'(i_count - 1'b1);
                end
            end
            MODE_POP_BACK: begin
                if (empty) begin
                    o_res.status = ST_EMPTY;
                end else begin
                    o_res.next_count = CNT_W'(i_count - 1'b1);
                end
            end
            MODE_READ: begin
                if (pos_c == '0 || pos_c > cnt_c || pos_c > CMP_W'(DEPTH)) begin
                    o_res.status = ST_BADPOS;
                end else begin
                    cmd.at      = IDX_W'(pos_c - 1'b1);
                    o_res.rd_ok = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // no movement in the row unless an item is taken
    always_comb begin
        o_cmd = cmd;
        if (!i_fire) begin
            o_cmd.act = ACT_HOLD;
        end
    end

endmodule

// File: design/bounded_sequence_list.sv
// ----------------------------------------------------------------------------
// bounded_sequence_list: ordered list of up to DEPTH words
// Deque with positional insert and read, built as a row of shifting cells.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one operation per item: mode (push front, push back,
//   insert after element max(position,1), pop front, pop back, read at a
//   1-based position), item_value and position. o_out returns exactly one
//   result item per operation: status, read_value and the new fill_count.
//   The result is registered and shows on o_out in the cycle after the
//   operation is taken. Throughput: one item per cycle while the result
//   register is free or being taken; every cell of the row shifts or loads
//   in the same cycle, so insert and pop front keep the same rate.
//   Reset (i_rst_n low, synchronous) empties the list and drops any
//   pending result; cell contents are not cleared and need no sweep.
//   When the receiver stalls, the result holds in the output register and
//   i_in.ready stays low until it is taken; an item is taken in the same
//   cycle the waiting result leaves.
//   An operation that fails (full, empty, bad position) leaves the list
//   unchanged and reports its status; unused modes report ok.
// ----------------------------------------------------------------------------
module bounded_sequence_list (
    input  logic i_clk,
    input  logic i_rst_n,
    bsl_in_if.sink    i_in,
    bsl_out_if.source o_out
);
    import bsl_pkg::*;

    t_cnt              r_count;
    logic              r_out_valid;
    t_status           r_status;
    logic [VALUE_W-1:0] r_read_value;
    t_cnt              r_fill;

    logic              fire;
    t_cell_cmd         cmd;
    t_ctrl_res         res;
    t_word             words [DEPTH];
    t_word             taps  [DEPTH];
    t_word             tap_or;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign fire       = i_in.valid && i_in.ready;

    bsl_ctrl u_ctrl (
        .i_fire     (fire),
        .i_mode     (i_in.mode),
        .i_value    ($unsigned(i_in.item_value)),
        .i_position (i_in.position),
        .i_count    (r_count),
        .o_cmd      (cmd),
        .o_res      (res)
    );

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        bsl_cell u_cell (
            .i_clk   (i_clk),
            .i_index (IDX_W'(g)),
            .i_cmd   (cmd),
            .i_left  (words[(g == 0) ? 0 : g - 1]),
            .i_right (words[(g == DEPTH - 1) ? DEPTH - 1 : g + 1]),
            .o_word  (words[g]),
            .o_tap   (taps[g])
        );
    end

    always_comb begin
        tap_or = '0;
        for (int i = 0; i < DEPTH; i++) begin
            tap_or = tap_or | taps[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (fire) begin
                r_count     <= res.next_count;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_status     <= res.status;
            r_read_value <= res.rd_ok ? from_word(tap_or) : '0;
            r_fill       <= res.next_count;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.status     = STATUS_W'(r_status);
    assign o_out.read_value = $signed(r_read_value);
    assign o_out.fill_count = FILL_W'(r_fill);

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("element count above depth");

    a_error_keeps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && res.status != ST_OK |=> $stable(r_count))
        else $error("failed operation changed the count");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && res.status == ST_OK && cmd.act == ACT_OPEN
        |=> r_count == CNT_W'($past(r_count) + 1'b1))
        else $error("push or insert did not grow the list by one");

    a_fill_tracks_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_fill == r_count)
        else $error("reported fill differs from held count");

    a_read_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_read_value != '0 |-> r_status == ST_OK)
        else $error("nonzero read value with error status");
`endif

endmodule

// File: dv/bsl_list_checker.sv
// ----------------------------------------------------------------------------
// bsl_list_checker: result checker for the bounded sequence list
// Watches both channels. Every accepted operation runs through a local copy
// of the list, and the predicted result is queued. Every accepted result is
// compared field by field with the oldest queued prediction.
// ----------------------------------------------------------------------------
module bsl_list_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    bsl_in_if    i_op_mon,
    bsl_out_if   i_res_mon,
    output int   o_fail_count,
    output int   o_pending
);
    import bsl_pkg::*;

    typedef struct {
        t_status               status;
        logic [VALUE_W-1:0]    read_value;
        logic [FILL_W-1:0]     fill_count;
    } t_op_result;

    t_word       list_cells [DEPTH];
    int unsigned list_len;
    t_op_result  expected_q [$];
    int          fail_cnt;

    // Runs one operation on the local list and returns its result
    function automatic t_op_result apply_list_op(input logic [MODE_W-1:0] mode,
                                                 input logic [VALUE_W-1:0] value,
                                                 input logic [POS_W-1:0] pos);
        t_op_result  r;
        t_word       word;
        int unsigned k;
        r.status     = ST_OK;
        r.read_value = '0;
        word         = t_word'(value);
        case (t_mode'(mode))
            MODE_PUSH_FRONT: begin
                if (list_len >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    for (int i = list_len; i > 0; i--) list_cells[i] = list_cells[i-1];
                    list_cells[0] = word;
                    list_len++;
                end
            end
            MODE_PUSH_BACK: begin
                if (list_len >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    list_cells[list_len] = word;
                    list_len++;
                end
            end
            MODE_INSERT: begin
                // position 0 behaves as position 1
                k = (pos < 1) ? 1 : pos;
                if (k > list_len) begin
                    r.status = ST_BADPOS;
                end else if (list_len >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    for (int i = list_len; i > k; i--) list_cells[i] = list_cells[i-1];
                    list_cells[k] = word;
                    list_len++;
                end
            end
            MODE_POP_FRONT: begin
                if (list_len == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    for (int i = 0; i + 1 < list_len; i++) list_cells[i] = list_cells[i+1];
                    list_len--;
                end
            end
            MODE_POP_BACK: begin
                if (list_len == 0) r.status = ST_EMPTY;
                else list_len--;
            end
            MODE_READ: begin
                if (pos == 0 || pos > list_len) r.status = ST_BADPOS;
                else r.read_value = VALUE_W'(list_cells[pos-1]);
            end
            default: ;  // spare codes change nothing
        endcase
        r.fill_count = FILL_W'(list_len);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_op_result exp_res;
        if (!i_rst_n) begin
            list_len = 0;
            expected_q.delete();
            fail_cnt = 0;
        end else begin
            // results first: a result never belongs to an item taken at the same edge
            if (i_res_mon.valid && i_res_mon.ready) begin
                if (expected_q.size() == 0) begin
                    $error("result with nothing expected: status %0d read_value %0d fill_count %0d",
                           i_res_mon.status, i_res_mon.read_value, i_res_mon.fill_count);
                    fail_cnt++;
                end else begin
                    exp_res = expected_q.pop_front();
                    if (i_res_mon.status !== exp_res.status) begin
                        $error("status: expected %0d, actual %0d",
                               exp_res.status, i_res_mon.status);
                        fail_cnt++;
                    end
                    if (i_res_mon.read_value !== exp_res.read_value) begin
                        $error("read_value: expected %0d, actual %0d",
                               $signed(exp_res.read_value), $signed(i_res_mon.read_value));
                        fail_cnt++;
                    end
                    if (i_res_mon.fill_count !== exp_res.fill_count) begin
                        $error("fill_count: expected %0d, actual %0d",
                               exp_res.fill_count, i_res_mon.fill_count);
                        fail_cnt++;
                    end
                end
            end
            if (i_op_mon.valid && i_op_mon.ready) begin
                expected_q.push_back(apply_list_op(i_op_mon.mode, i_op_mon.item_value,
                                                   i_op_mon.position));
            end
        end
        o_fail_count <= fail_cnt;
        o_pending    <= expected_q.size();
    end

endmodule

// File: dv/tb_bounded_sequence_list.sv
// ----------------------------------------------------------------------------
// tb_bounded_sequence_list: testbench top for the bounded sequence list
// Drives a directed run over the error and edge cases, then random
// operations in phases that alternate between filling and draining the list,
// with random idling on both channels. The checker does the prediction.
// ----------------------------------------------------------------------------
module tb_bounded_sequence_list;
    import bsl_pkg::*;

    localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

    localparam logic [VALUE_W-1:0] VAL_MIN  = 32'h8000_0000;
    localparam logic [VALUE_W-1:0] VAL_MAX  = 32'h7fff_ffff;
    localparam logic [VALUE_W-1:0] VAL_ZERO = 32'h0000_0000;
    localparam logic [VALUE_W-1:0] VAL_ONES = 32'hffff_ffff;

    localparam int RANDOM_OPS  = 1525;
    localparam int PHASE_OPS   = 48;
    localparam int HOLD_CYCLES = 250;
    localparam int HOLD_AT     = 300;
    localparam int STALL_LIMIT = 2000;
    localparam int TAIL_CYCLES = 4;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   stall_cycles;
    int   results_taken;
    bit   no_idle;

    bsl_in_if  op_ch ();
    bsl_out_if res_ch ();

    bounded_sequence_list u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (op_ch),
        .o_out   (res_ch)
    );

    bsl_list_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_op_mon     (op_ch),
        .i_res_mon    (res_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Offers one item after a random gap and returns once it is taken
    task automatic send_op(input logic [MODE_W-1:0] mode,
                           input logic [VALUE_W-1:0] value,
                           input logic [POS_W-1:0] pos);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            op_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        op_ch.valid      <= 1'b1;
        op_ch.mode       <= mode;
        op_ch.item_value <= value;
        op_ch.position   <= pos;
        do @(posedge i_clk); while (!op_ch.ready);
    endtask

    // Sender stops until every outstanding result is back
    task automatic wait_all_results;
        op_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic send_random_op(input bit fill_phase);
        int                  pick;
        logic [MODE_W-1:0]   mode;
        logic [VALUE_W-1:0]  value;
        pick = $urandom_range(0, 99);
        if (fill_phase) begin
            if (pick < 25)      mode = MODE_PUSH_FRONT;
            else if (pick < 50) mode = MODE_PUSH_BACK;
            else if (pick < 70) mode = MODE_INSERT;
            else if (pick < 80) mode = MODE_POP_FRONT;
            else if (pick < 90) mode = MODE_POP_BACK;
            else if (pick < 98) mode = MODE_READ;
            else                mode = (pick == 98) ? MODE_SPARE_LO : MODE_SPARE_HI;
        end else begin
            if (pick < 5)       mode = MODE_PUSH_FRONT;
            else if (pick < 10) mode = MODE_PUSH_BACK;
            else if (pick < 15) mode = MODE_INSERT;
            else if (pick < 48) mode = MODE_POP_FRONT;
            else if (pick < 80) mode = MODE_POP_BACK;
            else if (pick < 98) mode = MODE_READ;
            else                mode = (pick == 98) ? MODE_SPARE_LO : MODE_SPARE_HI;
        end
        case ($urandom_range(0, 15))
            0:       value = VAL_MIN;
            1:       value = VAL_MAX;
            2:       value = VAL_ZERO;
            3:       value = VAL_ONES;
            default: value = $urandom;
        endcase
        send_op(mode, value, POS_W'($urandom_range(0, 16)));
    endtask

    // Result side: random stalls, plus one long hold-off so the operation channel backs up
    initial begin
        int  stall;
        bit  held;
        held          = 1'b0;
        results_taken = 0;
        res_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (!held && results_taken >= HOLD_AT) begin
                held  = 1'b1;
                stall = HOLD_CYCLES;
            end else begin
                stall = no_idle ? 0 : $urandom_range(0, 13);
            end
            if (stall > 0) begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!res_ch.valid);
            results_taken++;
        end
    end

    // Ends the run when neither channel moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (op_ch.valid && op_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        no_idle           = 1'b0;
        i_rst_n          <= 1'b0;
        op_ch.valid      <= 1'b0;
        op_ch.mode       <= MODE_PUSH_FRONT;
        op_ch.item_value <= '0;
        op_ch.position   <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty list errors and spare codes
        send_op(MODE_POP_FRONT, VAL_ZERO, 5'd0);
        send_op(MODE_POP_BACK, VAL_ZERO, 5'd0);
        send_op(MODE_READ, VAL_ZERO, 5'd1);
        send_op(MODE_READ, VAL_ZERO, 5'd0);
        send_op(MODE_INSERT, VAL_MAX, 5'd0);
        send_op(MODE_INSERT, VAL_MAX, 5'd16);
        send_op(MODE_SPARE_LO, VAL_ONES, 5'd31);
        send_op(MODE_SPARE_HI, VAL_MIN, 5'd16);
        // extremes and inserts after the first and after the last element
        send_op(MODE_PUSH_BACK, VAL_MAX, 5'd0);
        send_op(MODE_PUSH_FRONT, VAL_MIN, 5'd0);
        send_op(MODE_READ, VAL_ZERO, 5'd1);
        send_op(MODE_READ, VAL_ZERO, 5'd2);
        send_op(MODE_READ, VAL_ZERO, 5'd3);
        send_op(MODE_INSERT, VAL_ONES, 5'd0);
        send_op(MODE_INSERT, VAL_ZERO, 5'd3);
        send_op(MODE_INSERT, 32'h5a5a_a5a5, 5'd5);
        send_op(MODE_READ, VAL_ZERO, 5'd4);
        send_op(MODE_READ, VAL_ZERO, 5'd16);
        send_op(MODE_POP_FRONT, VAL_ZERO, 5'd0);
        send_op(MODE_POP_BACK, VAL_ZERO, 5'd0);
        send_op(MODE_READ, VAL_ZERO, 5'd2);
        wait_all_results();

        for (int n = 0; n < RANDOM_OPS; n++) begin
            // every fourth block of items runs back to back on both sides
            no_idle = ((n / 100) % 4 == 1);
            send_random_op(((n / PHASE_OPS) % 2) == 0);
            if (n % 250 == 249) wait_all_results();
        end

        op_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
